### sv/nmea_chk_pkg.sv
// Shared types, character codes and helper functions for the NMEA checksum checker.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package nmea_chk_pkg;

    // Default sizes, handed to the top level as parameter defaults
    localparam int DEFAULT_BUFFER_BYTES = 128;
    localparam int DEFAULT_MAX_FIELDS   = 32;

    // Stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    // Framing characters
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_CR     = 8'h0D;

    // Hex digit ranges and offsets
    localparam logic [7:0] CHAR_0        = 8'h30;
    localparam logic [7:0] CHAR_9        = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F  = 8'h46;
    localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F  = 8'h66;
    localparam logic [7:0] OFFSET_DIGIT  = 8'h30;
    localparam logic [7:0] OFFSET_UPPER  = 8'h37;
    localparam logic [7:0] OFFSET_LOWER  = 8'h57;

    // Sentence type tags, first character in the high byte
    localparam logic [23:0] TAG_GGA = 24'h47_47_41;
    localparam logic [23:0] TAG_GSA = 24'h47_53_41;
    localparam logic [23:0] TAG_RMC = 24'h52_4D_43;
    localparam logic [23:0] TAG_GSV = 24'h47_53_56;

    // Sentence kind codes
    localparam logic [2:0] KIND_OTHER = 3'd0;
    localparam logic [2:0] KIND_GGA   = 3'd1;
    localparam logic [2:0] KIND_GSA   = 3'd2;
    localparam logic [2:0] KIND_RMC   = 3'd3;
    localparam logic [2:0] KIND_GSV   = 3'd4;

    typedef struct packed {
        logic [6:0] sentence_length;
        logic       overflowed;
        logic [5:0] field_count;
        logic [2:0] sentence_kind;
        logic [7:0] received_sum;
        logic [7:0] computed_sum;
        logic       checksum_ok;
    } verdict_t;

    // Decode one hex character: bit 4 flags a non-hex character, nibble then 0
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= CHAR_0 && c <= CHAR_9) begin
            v = c - OFFSET_DIGIT;
            return {1'b0, v[3:0]};
        end
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
            v = c - OFFSET_UPPER;
            return {1'b0, v[3:0]};
        end
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
            v = c - OFFSET_LOWER;
            return {1'b0, v[3:0]};
        end
        return 5'b1_0000;
    endfunction

endpackage

### sv/nmea_chk_core.sv
// Per-byte sentence tracker: checksum, digits, commas, address and length state.
// Depends on nmea_chk_pkg for character codes, kind codes and the verdict type.
`timescale 1ns / 1ps

module nmea_chk_core #(
    parameter int BUFFER_BYTES = nmea_chk_pkg::DEFAULT_BUFFER_BYTES,
    parameter int MAX_FIELDS   = nmea_chk_pkg::DEFAULT_MAX_FIELDS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_valid,
    input  logic [7:0]            step_byte,
    input  logic                  enable,
    output logic                  res_valid,
    output nmea_chk_pkg::verdict_t res
);

    localparam int PW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(MAX_FIELDS + 1);
    localparam logic [PW-1:0] POS_LIMIT   = PW'(BUFFER_BYTES - 1);
    localparam logic [CW-1:0] FIELD_LIMIT = CW'(MAX_FIELDS);

    localparam logic [1:0] PH_BODY   = 2'd0;
    localparam logic [1:0] PH_FIRST  = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    logic          in_sentence_reg, in_sentence_next;
    logic [1:0]    phase_reg, phase_next;
    logic [7:0]    xor_reg, xor_next;
    logic [3:0]    high_nib_reg, high_nib_next;
    logic [3:0]    low_nib_reg, low_nib_next;
    logic [1:0]    digit_cnt_reg, digit_cnt_next;
    logic          bad_reg, bad_next;
    logic [CW-1:0] comma_reg, comma_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [23:0]   addr_reg, addr_next;
    logic [1:0]    addr_len_reg, addr_len_next;
    logic          ovf_reg, ovf_next;

    logic [4:0]    hex;
    logic [PW-1:0] pos_inc;
    logic          ovf_upd;
    logic [7:0]    rsum;
    logic [PW+6:0] pos_ext;
    logic [CW+5:0] comma_ext;

    always_comb
    begin
        hex       = nmea_chk_pkg::hex_decode(step_byte);
        pos_inc   = (pos_reg < POS_LIMIT) ? pos_reg + PW'(1) : pos_reg;
        ovf_upd   = ovf_reg | (pos_inc >= POS_LIMIT);
        rsum      = {high_nib_reg, low_nib_reg};
        pos_ext   = {7'd0, pos_inc};
        comma_ext = {6'd0, comma_reg};

        res.checksum_ok     = (phase_reg != PH_BODY) && (digit_cnt_reg == 2'd2) &&
                              !bad_reg && (xor_reg == rsum);
        res.computed_sum    = xor_reg;
        res.received_sum    = rsum;
        res.field_count     = comma_ext[5:0];
        res.overflowed      = ovf_upd;
        res.sentence_length = pos_ext[6:0];
        if (addr_len_reg != 2'd3) begin
            res.sentence_kind = nmea_chk_pkg::KIND_OTHER;
        end else if (addr_reg == nmea_chk_pkg::TAG_GGA) begin
            res.sentence_kind = nmea_chk_pkg::KIND_GGA;
        end else if (addr_reg == nmea_chk_pkg::TAG_GSA) begin
            res.sentence_kind = nmea_chk_pkg::KIND_GSA;
        end else if (addr_reg == nmea_chk_pkg::TAG_RMC) begin
            res.sentence_kind = nmea_chk_pkg::KIND_RMC;
        end else if (addr_reg == nmea_chk_pkg::TAG_GSV) begin
            res.sentence_kind = nmea_chk_pkg::KIND_GSV;
        end else begin
            res.sentence_kind = nmea_chk_pkg::KIND_OTHER;
        end

        res_valid        = 1'b0;
        in_sentence_next = in_sentence_reg;
        phase_next       = phase_reg;
        xor_next         = xor_reg;
        high_nib_next    = high_nib_reg;
        low_nib_next     = low_nib_reg;
        digit_cnt_next   = digit_cnt_reg;
        bad_next         = bad_reg;
        comma_next       = comma_reg;
        pos_next         = pos_reg;
        addr_next        = addr_reg;
        addr_len_next    = addr_len_reg;
        ovf_next         = ovf_reg;

        if (step_valid) begin
            if (step_byte == nmea_chk_pkg::CHAR_DOLLAR) begin
                // restart the sentence, also from inside one
                in_sentence_next = 1'b1;
                phase_next       = PH_BODY;
                xor_next         = 8'h00;
                high_nib_next    = 4'h0;
                low_nib_next     = 4'h0;
                digit_cnt_next   = 2'd0;
                bad_next         = 1'b0;
                comma_next       = '0;
                pos_next         = '0;
                addr_next        = 24'h0;
                addr_len_next    = 2'd0;
                ovf_next         = 1'b0;
            end else if (in_sentence_reg) begin
                pos_next = pos_inc;
                ovf_next = ovf_upd;
                if (step_byte == nmea_chk_pkg::CHAR_CR) begin
                    res_valid        = enable;
                    in_sentence_next = 1'b0;
                end else begin
                    case (phase_reg)
                        PH_BODY:
                        begin
                            if (step_byte == nmea_chk_pkg::CHAR_STAR) begin
                                phase_next = PH_FIRST;
                            end else begin
                                xor_next = xor_reg ^ step_byte;
                                if (step_byte == nmea_chk_pkg::CHAR_COMMA) begin
                                    if (comma_reg < FIELD_LIMIT) begin
                                        comma_next = comma_reg + CW'(1);
                                    end
                                end else if (comma_reg == '0) begin
                                    addr_next = {addr_reg[15:0], step_byte};
                                    if (addr_len_reg != 2'd3) begin
                                        addr_len_next = addr_len_reg + 2'd1;
                                    end
                                end
                            end
                        end
                        PH_FIRST:
                        begin
                            high_nib_next  = hex[3:0];
                            bad_next       = bad_reg | hex[4];
                            digit_cnt_next = digit_cnt_reg + 2'd1;
                            phase_next     = PH_SECOND;
                        end
                        PH_SECOND:
                        begin
                            low_nib_next   = hex[3:0];
                            bad_next       = bad_reg | hex[4];
                            digit_cnt_next = digit_cnt_reg + 2'd1;
                            phase_next     = PH_DONE;
                        end
                        default:
                        begin
                            // drop trailing bytes until CR
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_sentence_reg <= 1'b0;
            phase_reg       <= PH_BODY;
            xor_reg         <= 8'h00;
            high_nib_reg    <= 4'h0;
            low_nib_reg     <= 4'h0;
            digit_cnt_reg   <= 2'd0;
            bad_reg         <= 1'b0;
            comma_reg       <= '0;
            pos_reg         <= '0;
            addr_reg        <= 24'h0;
            addr_len_reg    <= 2'd0;
            ovf_reg         <= 1'b0;
        end else begin
            in_sentence_reg <= in_sentence_next;
            phase_reg       <= phase_next;
            xor_reg         <= xor_next;
            high_nib_reg    <= high_nib_next;
            low_nib_reg     <= low_nib_next;
            digit_cnt_reg   <= digit_cnt_next;
            bad_reg         <= bad_next;
            comma_reg       <= comma_next;
            pos_reg         <= pos_next;
            addr_reg        <= addr_next;
            addr_len_reg    <= addr_len_next;
            ovf_reg         <= ovf_next;
        end
    end

endmodule

### sv/nmea_chk_outbuf.sv
// Two-entry output register with skid stage for verdict words.
// Depends on nmea_chk_pkg for the verdict type.
`timescale 1ns / 1ps

module nmea_chk_outbuf (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_valid,
    input  nmea_chk_pkg::verdict_t push_res,
    output logic                   push_ready,
    output logic                   pop_valid,
    output nmea_chk_pkg::verdict_t pop_res,
    input  logic                   pop_ready
);

    logic                   main_valid_reg, main_valid_next;
    logic                   skid_valid_reg, skid_valid_next;
    nmea_chk_pkg::verdict_t main_reg, main_next;
    nmea_chk_pkg::verdict_t skid_reg, skid_next;

    assign push_ready = !skid_valid_reg;
    assign pop_valid  = main_valid_reg;
    assign pop_res    = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;

        if (main_valid_reg && pop_ready) begin
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = 1'b0;
            end
        end

        if (push_valid && !skid_valid_reg) begin
            if (!main_valid_next) begin
                main_next       = push_res;
                main_valid_next = 1'b1;
            end else begin
                skid_next       = push_res;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

### sv/nmea_sentence_checksum_checker.sv
// Top level of the NMEA 0183 sentence checksum checker: input register, enable register.
// Depends on nmea_chk_pkg, nmea_chk_core and nmea_chk_outbuf.
`timescale 1ns / 1ps

// Feed received UART characters one word per cycle on the s_axis side. A '$'
// opens a sentence; every character up to '*' is XORed, the two hex digits after
// '*' (either case) form the received checksum, commas are counted, and the last
// three address characters give the sentence kind. A CR closes the sentence and,
// while enable is 1, delivers one verdict word on m_axis. Characters outside a
// sentence are dropped. Throughput is one character per clock, sustained as long
// as m_axis takes verdicts; the tracker updates all of its state from the
// registered character. A CR passes the input register, the tracker forms its
// verdict, and the verdict is registered in the output buffer before m_axis
// shows it. The two-entry output buffer keeps input flowing while a verdict
// waits; input stalls only when both entries are full.
// Write enable only while the block is idle.

module nmea_sentence_checksum_checker #(
    parameter int BUFFER_BYTES = nmea_chk_pkg::DEFAULT_BUFFER_BYTES,
    parameter int MAX_FIELDS   = nmea_chk_pkg::DEFAULT_MAX_FIELDS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration: the enable register
    input  logic                                 cfg_we,
    input  logic                                 cfg_wdata,
    // input characters
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [7:0] rx_byte
    input  logic [nmea_chk_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // verdict words
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [0] checksum_ok, [8:1] computed_sum, [16:9] received_sum,
    // [19:17] sentence_kind, [25:20] field_count, [26] overflowed,
    // [33:27] sentence_length, [39:34] zero
    output logic [nmea_chk_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    logic                   enable_reg;
    logic                   in_valid_reg, in_valid_next;
    logic [7:0]             in_byte_reg;
    logic                   push_ready;
    logic                   advance;
    logic                   res_valid;
    nmea_chk_pkg::verdict_t res;
    nmea_chk_pkg::verdict_t out_res;

    // Advance the held character only when the output buffer has room
    assign advance       = in_valid_reg && push_ready;
    assign s_axis_tready = !in_valid_reg || push_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tready) begin
            in_valid_next = s_axis_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
            enable_reg   <= 1'b1;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_we) begin
                enable_reg <= cfg_wdata;
            end
        end
    end

    // Hold the character payload while it waits
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    nmea_chk_core #(
        .BUFFER_BYTES(BUFFER_BYTES),
        .MAX_FIELDS  (MAX_FIELDS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_valid(advance),
        .step_byte (in_byte_reg),
        .enable    (enable_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    nmea_chk_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(res_valid),
        .push_res  (res),
        .push_ready(push_ready),
        .pop_valid (m_axis_tvalid),
        .pop_res   (out_res),
        .pop_ready (m_axis_tready)
    );

    // Pack the verdict, last field in the lowest bit, zero fill to whole bytes
    assign m_axis_tdata = {6'd0, out_res};

endmodule
